@@ hw/rtl/gst_pkg.sv @@
// Shared types and constants for the greedy group Steiner tree block.
// No dependencies; imported by every module of the block except gst_ram.

package gst_pkg;

  localparam int DEF_MAX_VERTICES = 256;
  localparam int DEF_MAX_EDGES    = 1024;
  localparam int DEF_MAX_GROUPS   = 32;
  localparam int DEF_MAX_MEMBERS  = 256;

  localparam int IN_DATA_W  = 48;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 9;

  localparam int VC_W   = 9;
  localparam int GC_W   = 6;
  localparam int VTX_W  = 8;
  localparam int COST_W = 12;
  localparam int GRP_W  = 5;
  localparam int DIST_W = 16;

  localparam logic [DIST_W-1:0] DIST_FAR = 16'd40000;

  localparam logic [IN_USER_W-1:0] KIND_EDGE   = 2'd0;
  localparam logic [IN_USER_W-1:0] KIND_MEMBER = 2'd1;
  localparam logic [IN_USER_W-1:0] KIND_START  = 2'd2;

  localparam logic [CFG_ADDR_W-1:0] CFG_VERTEX_COUNT = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_GROUP_COUNT  = 1'b1;

  typedef struct packed {
    logic start;
    logic bank;
  } srch_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } srch_sts_t;

endpackage

@@ hw/rtl/gst_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
// Uses no package items.

module gst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/gst_search.sv @@
// Single-source array-scan shortest path engine with edge, distance and
// predecessor memories. Depends on gst_pkg and gst_ram.

module gst_search import gst_pkg::*; #(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int MAX_EDGES    = DEF_MAX_EDGES,
  localparam int VW  = $clog2(MAX_VERTICES),
  localparam int NW  = (VW + 1 > VC_W) ? VW + 1 : VC_W,
  localparam int EW  = $clog2(MAX_EDGES + 1),
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              ld_en,
  input  logic [VTX_W-1:0]  ld_src,
  input  logic [VTX_W-1:0]  ld_dst,
  input  logic [COST_W-1:0] ld_cost,
  input  srch_ctl_t         ctl,
  input  logic [VW-1:0]     src,
  input  logic [NW-1:0]     nv,
  output srch_sts_t         sts,
  input  logic [VW-1:0]     qry_addr,
  input  logic              qry_bank,
  output logic [DIST_W-1:0] qry_dist,
  output logic [VW-1:0]     qry_pred
);

  typedef enum logic [2:0] {
    S_IDLE, S_CLR, S_SCAN, S_SCAN_END, S_SET, S_E_RD, S_E_CHK, S_V_CHK
  } state_t;

  state_t            state_r;
  logic [EW-1:0]     edge_total_r;
  logic [EW-1:0]     e_r;
  logic [NW-1:0]     nv_r;
  logic [NW-1:0]     cnt_r;
  logic [VW-1:0]     src_r;
  logic              bank_r;
  logic              rd_v_r;
  logic [VW-1:0]     rd_i_r;
  logic [DIST_W-1:0] best_r;
  logic              found_r;
  logic [VW-1:0]     u_r;
  logic [VW-1:0]     v_r;
  logic [DIST_W:0]   nd_r;
  logic              done_r;

  logic              d_we;
  logic [VW-1:0]     d_waddr;
  logic [DIST_W:0]   d_wdata;
  logic [VW-1:0]     d_raddr;
  logic [DIST_W:0]   d_rdata;
  logic              p_we;
  logic [VW:0]       p_waddr;
  logic [VW-1:0]     p_rdata;
  logic [EAW-1:0]    e_raddr;
  logic [2*VTX_W+COST_W-1:0] e_rdata;

  logic [NW-1:0]     e_src_x;
  logic [NW-1:0]     e_dst_x;
  logic              edge_hit;
  logic              better;
  logic              last_edge;

  gst_ram #(.WIDTH(2*VTX_W+COST_W), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk   (clk),
    .we    (ld_en && (edge_total_r < EW'(MAX_EDGES))),
    .waddr (edge_total_r[EAW-1:0]),
    .wdata ({ld_cost, ld_dst, ld_src}),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  gst_ram #(.WIDTH(DIST_W+1), .DEPTH(MAX_VERTICES)) u_dist_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .raddr (d_raddr),
    .rdata (d_rdata)
  );

  gst_ram #(.WIDTH(VW), .DEPTH(2*MAX_VERTICES)) u_pred_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (u_r),
    .raddr ({qry_bank, qry_addr}),
    .rdata (p_rdata)
  );

  assign e_raddr   = e_r[EAW-1:0];
  assign e_src_x   = NW'(e_rdata[VTX_W-1:0]);
  assign e_dst_x   = NW'(e_rdata[2*VTX_W-1:VTX_W]);
  assign edge_hit  = (e_src_x == NW'(u_r)) && (e_dst_x < nv_r);
  assign better    = rd_v_r && !d_rdata[DIST_W] && (d_rdata[DIST_W-1:0] < best_r);
  assign last_edge = (e_r + EW'(1)) == edge_total_r;

  assign qry_dist = d_rdata[DIST_W-1:0];
  assign qry_pred = p_rdata;
  assign sts.busy = (state_r != S_IDLE);
  assign sts.done = done_r;

  always_comb begin
    d_we    = 1'b0;
    d_waddr = cnt_r[VW-1:0];
    d_wdata = {1'b0, DIST_FAR};
    p_we    = 1'b0;
    p_waddr = {bank_r, v_r};
    d_raddr = qry_addr;
    unique case (state_r)
      S_CLR: begin
        d_we    = 1'b1;
        d_wdata = (cnt_r[VW-1:0] == src_r) ? '0 : {1'b0, DIST_FAR};
      end
      S_SCAN: begin
        d_raddr = cnt_r[VW-1:0];
      end
      S_SET: begin
        d_we    = 1'b1;
        d_waddr = u_r;
        d_wdata = {1'b1, best_r};
      end
      S_E_CHK: begin
        d_raddr = e_dst_x[VW-1:0];
      end
      S_V_CHK: begin
        if (!d_rdata[DIST_W] && (nd_r < {1'b0, d_rdata[DIST_W-1:0]})) begin
          d_we    = 1'b1;
          d_waddr = v_r;
          d_wdata = {1'b0, nd_r[DIST_W-1:0]};
          p_we    = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      edge_total_r <= '0;
      done_r       <= 1'b0;
      rd_v_r       <= 1'b0;
    end else begin
      done_r <= 1'b0;
      rd_v_r <= (state_r == S_SCAN);
      rd_i_r <= cnt_r[VW-1:0];
      if (ld_en && (edge_total_r < EW'(MAX_EDGES))) begin
        edge_total_r <= edge_total_r + EW'(1);
      end
      if (better) begin
        best_r  <= d_rdata[DIST_W-1:0];
        u_r     <= rd_i_r;
        found_r <= 1'b1;
      end
      unique case (state_r)
        S_IDLE: begin
          if (ctl.start) begin
            src_r   <= src;
            nv_r    <= nv;
            bank_r  <= ctl.bank;
            cnt_r   <= '0;
            state_r <= S_CLR;
          end
        end
        S_CLR: begin
          if (cnt_r == nv_r - NW'(1)) begin
            cnt_r   <= '0;
            best_r  <= DIST_FAR;
            found_r <= 1'b0;
            state_r <= S_SCAN;
          end else begin
            cnt_r <= cnt_r + NW'(1);
          end
        end
        S_SCAN: begin
          if (cnt_r == nv_r - NW'(1)) begin
            state_r <= S_SCAN_END;
          end else begin
            cnt_r <= cnt_r + NW'(1);
          end
        end
        S_SCAN_END: begin
          if (found_r || better) begin
            state_r <= S_SET;
          end else begin
            done_r  <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        S_SET: begin
          e_r <= '0;
          if (edge_total_r == '0) begin
            cnt_r   <= '0;
            best_r  <= DIST_FAR;
            found_r <= 1'b0;
            state_r <= S_SCAN;
          end else begin
            state_r <= S_E_RD;
          end
        end
        S_E_RD: begin
          state_r <= S_E_CHK;
        end
        S_E_CHK: begin
          v_r  <= e_dst_x[VW-1:0];
          nd_r <= {1'b0, best_r} + (DIST_W+1)'(e_rdata[2*VTX_W+COST_W-1:2*VTX_W]);
          if (edge_hit) begin
            state_r <= S_V_CHK;
          end else if (last_edge) begin
            cnt_r   <= '0;
            best_r  <= DIST_FAR;
            found_r <= 1'b0;
            state_r <= S_SCAN;
          end else begin
            e_r     <= e_r + EW'(1);
            state_r <= S_E_RD;
          end
        end
        S_V_CHK: begin
          if (last_edge) begin
            cnt_r   <= '0;
            best_r  <= DIST_FAR;
            found_r <= 1'b0;
            state_r <= S_SCAN;
          end else begin
            e_r     <= e_r + EW'(1);
            state_r <= S_E_RD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/group_steiner_tree_greedy.sv @@
// Top level of the greedy group Steiner tree block: load path, round control,
// tree memories and result register. Depends on gst_pkg, gst_ram, gst_search.
//
// Usage:
//   Input stream: in_tuser selects the item kind (edge, member, start).
//   Edge and member items are taken one per cycle while the block is idle.
//   A start item rebuilds the tree; in_tready stays low until the run's
//   last result has been handed to the output register.
//   Output stream: one transfer per joined group, group 0 first with cost 0;
//   out_tlast marks the final transfer, which is the one that reports an
//   unreachable group if the run stops early.
//   Run time: a clearing sweep of the tree flags, then per round one search
//   per usable member of every unjoined group. Each search clears the
//   distance memory, then per settled vertex scans all vertices and walks
//   every loaded edge; the edge scan in the shortest path engine sets the
//   pace.
//   The first result, group 0, follows the clearing sweep and the search
//   for the seed among the members.
//   Reset empties the edge and member lists and restores the registers to
//   256 vertices and 32 groups.
//   A stalled receiver holds the output register; the run goes on and waits
//   with its next result until the pending transfer completes.

module group_steiner_tree_greedy import gst_pkg::*; #(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int MAX_EDGES    = DEF_MAX_EDGES,
  parameter int MAX_GROUPS   = DEF_MAX_GROUPS,
  parameter int MAX_MEMBERS  = DEF_MAX_MEMBERS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // edge_from, edge_to, edge_weight, member_group, member_vertex, zero fill
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // kind
  input  logic [IN_USER_W-1:0]  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // group_index, join_cost, unreachable, zero fill
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int NW  = (VW + 1 > VC_W) ? VW + 1 : VC_W;
  localparam int GNW = 7;
  localparam int GW  = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int MW  = $clog2(MAX_MEMBERS + 1);
  localparam int MAW = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;

  typedef enum logic [4:0] {
    C_IDLE, C_CLR, C_SEED_RD, C_SEED_CHK, C_EMIT0, C_ROUND, C_G_CHK, C_M_RD,
    C_M_CHK, C_M_NEXT, C_S_WAIT, C_T_RD, C_T_Q, C_T_CHK, C_T_END, C_R_END,
    C_W_RD, C_W_CHK, C_W_DONE, C_EMIT
  } state_t;

  state_t              state_r;
  logic [VC_W-1:0]     vc_r;
  logic [GC_W-1:0]     gc_r;
  logic [NW-1:0]       nv_r;
  logic [GNW-1:0]      ng_r;
  logic [GNW-1:0]      n_r;
  logic [GNW-1:0]      g_r;
  logic [MW-1:0]       mem_total_r;
  logic [MW-1:0]       m_r;
  logic [NW-1:0]       cnt_r;
  logic [NW-1:0]       tree_size_r;
  logic [NW-1:0]       k_r;
  logic [MAX_GROUPS-1:0] joined_r;
  logic                best_bank_r;
  logic                have_r;
  logic [DIST_W-1:0]   b_cost_r;
  logic [GNW-1:0]      b_group_r;
  logic [VW-1:0]       b_src_r;
  logic [VW-1:0]       b_tgt_r;
  logic [VW-1:0]       src_r;
  logic                found_r;
  logic [DIST_W-1:0]   td_r;
  logic [VW-1:0]       tv_r;
  logic [VW-1:0]       x_r;
  logic [NW-1:0]       steps_r;
  logic [GRP_W-1:0]    res_group_r;
  logic [DIST_W-1:0]   res_cost_r;
  logic                res_unr_r;
  logic                res_last_r;
  logic                out_valid_r;
  logic [GRP_W-1:0]    out_group_r;
  logic [DIST_W-1:0]   out_cost_r;
  logic                out_unr_r;
  logic                out_last_r;

  logic                in_fire;
  logic [NW-1:0]       nv_c;
  logic [GNW-1:0]      ng_c;
  logic [GNW-1:0]      low_g;
  logic [GRP_W+VTX_W-1:0] m_rdata;
  logic [GNW-1:0]      m_grp_x;
  logic [NW-1:0]       m_vtx_x;
  logic                m_usable;
  logic                it_we;
  logic [VW-1:0]       it_waddr;
  logic                it_wdata;
  logic                it_rdata;
  logic                to_we;
  logic [VW-1:0]       to_waddr;
  logic [VW-1:0]       to_rdata;
  srch_ctl_t           s_ctl;
  srch_sts_t           s_sts;
  logic [VW-1:0]       qry_addr;
  logic [DIST_W-1:0]   qry_dist;
  logic [VW-1:0]       qry_pred;
  logic                out_free;

  assign in_fire  = in_tvalid && in_tready;
  assign in_tready = (state_r == C_IDLE);
  assign out_free = !out_valid_r || out_tready;

  assign nv_c = (vc_r == '0) ? NW'(1) :
                ((NW'(vc_r) > NW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : NW'(vc_r));
  assign ng_c = (gc_r == '0) ? GNW'(1) :
                ((GNW'(gc_r) > GNW'(MAX_GROUPS)) ? GNW'(MAX_GROUPS) : GNW'(gc_r));

  assign m_grp_x  = GNW'(m_rdata[GRP_W+VTX_W-1:VTX_W]);
  assign m_vtx_x  = NW'(m_rdata[VTX_W-1:0]);
  assign m_usable = (m_grp_x == g_r) && (m_vtx_x < nv_r);

  always_comb begin
    low_g = ng_r;
    for (int i = MAX_GROUPS - 1; i >= 0; i--) begin
      if (!joined_r[i] && (GNW'(i) < ng_r)) begin
        low_g = GNW'(i);
      end
    end
  end

  gst_ram #(.WIDTH(GRP_W+VTX_W), .DEPTH(MAX_MEMBERS)) u_member_ram (
    .clk   (clk),
    .we    (in_fire && (in_tuser == KIND_MEMBER) && (mem_total_r < MW'(MAX_MEMBERS))),
    .waddr (mem_total_r[MAW-1:0]),
    .wdata ({in_tdata[32:28], in_tdata[40:33]}),
    .raddr (m_r[MAW-1:0]),
    .rdata (m_rdata)
  );

  gst_ram #(.WIDTH(1), .DEPTH(MAX_VERTICES)) u_in_tree_ram (
    .clk   (clk),
    .we    (it_we),
    .waddr (it_waddr),
    .wdata (it_wdata),
    .raddr (x_r),
    .rdata (it_rdata)
  );

  gst_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_tree_order_ram (
    .clk   (clk),
    .we    (to_we),
    .waddr (to_waddr),
    .wdata (it_waddr),
    .raddr (k_r[VW-1:0]),
    .rdata (to_rdata)
  );

  gst_search #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_search (
    .clk      (clk),
    .rst_n    (rst_n),
    .ld_en    (in_fire && (in_tuser == KIND_EDGE)),
    .ld_src   (in_tdata[7:0]),
    .ld_dst   (in_tdata[15:8]),
    .ld_cost  (in_tdata[27:16]),
    .ctl      (s_ctl),
    .src      (m_vtx_x[VW-1:0]),
    .nv       (nv_r),
    .sts      (s_sts),
    .qry_addr (qry_addr),
    .qry_bank (best_bank_r),
    .qry_dist (qry_dist),
    .qry_pred (qry_pred)
  );

  always_comb begin
    it_we     = 1'b0;
    it_waddr  = x_r;
    it_wdata  = 1'b1;
    to_we     = 1'b0;
    to_waddr  = tree_size_r[VW-1:0];
    qry_addr  = x_r;
    s_ctl.start = (state_r == C_M_CHK) && m_usable;
    s_ctl.bank  = !best_bank_r;
    unique case (state_r)
      C_CLR: begin
        it_we    = 1'b1;
        it_waddr = cnt_r[VW-1:0];
        it_wdata = 1'b0;
      end
      C_SEED_CHK: begin
        if ((m_grp_x == '0) && (m_vtx_x < nv_r)) begin
          it_we    = 1'b1;
          it_waddr = m_vtx_x[VW-1:0];
          to_we    = 1'b1;
        end
      end
      C_T_Q: begin
        qry_addr = to_rdata;
      end
      C_W_CHK: begin
        if (!it_rdata) begin
          it_we = 1'b1;
          to_we = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= C_IDLE;
      vc_r        <= VC_W'(256);
      gc_r        <= GC_W'(32);
      mem_total_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_VERTEX_COUNT: vc_r <= cfg_wdata[VC_W-1:0];
          CFG_GROUP_COUNT:  gc_r <= cfg_wdata[GC_W-1:0];
          default: begin
          end
        endcase
      end
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (to_we) begin
        tree_size_r <= tree_size_r + NW'(1);
      end
      unique case (state_r)
        C_IDLE: begin
          if (in_fire) begin
            unique case (in_tuser)
              KIND_MEMBER: begin
                if (mem_total_r < MW'(MAX_MEMBERS)) begin
                  mem_total_r <= mem_total_r + MW'(1);
                end
              end
              KIND_START: begin
                nv_r        <= nv_c;
                ng_r        <= ng_c;
                joined_r    <= '0;
                tree_size_r <= '0;
                best_bank_r <= 1'b0;
                cnt_r       <= '0;
                state_r     <= C_CLR;
              end
              default: begin
              end
            endcase
          end
        end
        C_CLR: begin
          m_r <= '0;
          if (cnt_r == nv_r - NW'(1)) begin
            state_r <= (mem_total_r == '0) ? C_EMIT0 : C_SEED_RD;
          end else begin
            cnt_r <= cnt_r + NW'(1);
          end
        end
        C_SEED_RD: state_r <= C_SEED_CHK;
        C_SEED_CHK: begin
          if ((m_grp_x == '0) && (m_vtx_x < nv_r)) begin
            state_r <= C_EMIT0;
          end else if (m_r + MW'(1) == mem_total_r) begin
            state_r <= C_EMIT0;
          end else begin
            m_r     <= m_r + MW'(1);
            state_r <= C_SEED_RD;
          end
        end
        C_EMIT0: begin
          joined_r[0] <= 1'b1;
          res_group_r <= '0;
          res_cost_r  <= '0;
          res_unr_r   <= 1'b0;
          res_last_r  <= (ng_r == GNW'(1));
          n_r         <= GNW'(1);
          state_r     <= C_EMIT;
        end
        C_ROUND: begin
          have_r  <= 1'b0;
          g_r     <= '0;
          state_r <= C_G_CHK;
        end
        C_G_CHK: begin
          m_r <= '0;
          if (g_r == ng_r) begin
            state_r <= C_R_END;
          end else if (joined_r[g_r[GW-1:0]] || (mem_total_r == '0)) begin
            g_r <= g_r + GNW'(1);
          end else begin
            state_r <= C_M_RD;
          end
        end
        C_M_RD: state_r <= C_M_CHK;
        C_M_CHK: begin
          src_r <= m_vtx_x[VW-1:0];
          state_r <= m_usable ? C_S_WAIT : C_M_NEXT;
        end
        C_M_NEXT: begin
          if (m_r + MW'(1) == mem_total_r) begin
            g_r     <= g_r + GNW'(1);
            state_r <= C_G_CHK;
          end else begin
            m_r     <= m_r + MW'(1);
            state_r <= C_M_RD;
          end
        end
        C_S_WAIT: begin
          k_r     <= '0;
          found_r <= 1'b0;
          if (s_sts.done) begin
            state_r <= (tree_size_r == '0) ? C_T_END : C_T_RD;
          end
        end
        C_T_RD: state_r <= C_T_Q;
        C_T_Q: begin
          tv_r    <= to_rdata;
          state_r <= C_T_CHK;
        end
        C_T_CHK: begin
          if ((qry_dist < DIST_FAR) && (!found_r || (qry_dist < td_r))) begin
            found_r <= 1'b1;
            td_r    <= qry_dist;
            x_r     <= tv_r;
          end
          if (k_r + NW'(1) == tree_size_r) begin
            state_r <= C_T_END;
          end else begin
            k_r     <= k_r + NW'(1);
            state_r <= C_T_RD;
          end
        end
        C_T_END: begin
          if (found_r && (!have_r || (td_r < b_cost_r))) begin
            have_r      <= 1'b1;
            b_cost_r    <= td_r;
            b_group_r   <= g_r;
            b_src_r     <= src_r;
            b_tgt_r     <= x_r;
            best_bank_r <= !best_bank_r;
          end
          state_r <= C_M_NEXT;
        end
        C_R_END: begin
          if (!have_r) begin
            res_group_r <= low_g[GRP_W-1:0];
            res_cost_r  <= DIST_FAR;
            res_unr_r   <= 1'b1;
            res_last_r  <= 1'b1;
            state_r     <= C_EMIT;
          end else begin
            x_r     <= b_tgt_r;
            steps_r <= '0;
            state_r <= C_W_RD;
          end
        end
        C_W_RD: state_r <= C_W_CHK;
        C_W_CHK: begin
          if ((x_r == b_src_r) || (steps_r >= nv_r) || (NW'(qry_pred) >= nv_r)) begin
            state_r <= C_W_DONE;
          end else begin
            x_r     <= qry_pred;
            steps_r <= steps_r + NW'(1);
            state_r <= C_W_RD;
          end
        end
        C_W_DONE: begin
          joined_r[b_group_r[GW-1:0]] <= 1'b1;
          res_group_r <= b_group_r[GRP_W-1:0];
          res_cost_r  <= b_cost_r;
          res_unr_r   <= 1'b0;
          res_last_r  <= (n_r + GNW'(1) == ng_r);
          n_r         <= n_r + GNW'(1);
          state_r     <= C_EMIT;
        end
        C_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_group_r <= res_group_r;
            out_cost_r  <= res_cost_r;
            out_unr_r   <= res_unr_r;
            out_last_r  <= res_last_r;
            state_r     <= res_last_r ? C_IDLE : C_ROUND;
          end
        end
        default: state_r <= C_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_unr_r, out_cost_r, out_group_r};
  assign out_tlast  = out_last_r;

endmodule

@@ hw/rtl/gst_chk.sv @@
// Port-level checker for the greedy group Steiner tree block, bound to the
// top level. Depends on gst_pkg.

module gst_chk import gst_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [IN_USER_W-1:0]  in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_unr_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[21] |-> out_tlast)
    else $error("unreachable result not last");

  a_unr_cost: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[21] |-> out_tdata[20:5] == DIST_FAR)
    else $error("unreachable result has wrong cost");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == KIND_START |=> !in_tready)
    else $error("input taken right after start");

endmodule

bind group_steiner_tree_greedy gst_chk u_gst_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

@@ sim/testbench.sv @@
// Self-checking testbench for group_steiner_tree_greedy: loads edges and group members,
// starts tree builds under several register settings, and predicts every join transfer.
// Depends on gst_pkg and the block's RTL only.
`timescale 1ns / 100ps

module testbench;
  import gst_pkg::*;

  localparam logic [IN_USER_W-1:0] KIND_NONE = 2'd3;
  localparam int FAR        = 40000;
  localparam int QUIET      = 64;
  localparam int LIMIT      = 400000000;
  localparam int RAND_ITEMS = 290;

  typedef struct {
    bit                    is_cfg;
    logic [IN_USER_W-1:0]  kind;
    logic [7:0]            efrom;
    logic [7:0]            eto;
    logic [11:0]           ew;
    logic [4:0]            mg;
    logic [7:0]            mv;
    logic [CFG_ADDR_W-1:0] cidx;
    logic [CFG_DATA_W-1:0] cval;
  } pend_t;

  typedef struct {
    logic [4:0]  grp;
    logic [15:0] cost;
    logic        unr;
    logic        last;
  } join_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [IN_USER_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tlast;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  group_steiner_tree_greedy i_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  int vc_reg = 256;
  int gc_reg = 32;
  int e_src[$];
  int e_dst[$];
  int e_cost[$];
  int m_grp[$];
  int m_vtx[$];
  int vdist[256];
  bit settled[256];
  int vpred[256];
  int bpred[256];
  bit in_tree[256];
  bit joined[32];
  int tree_order[$];

  pend_t pending[$];
  join_t joins_due[$];
  int errs = 0;
  int seen = 0;
  int cycles = 0;

  task automatic shortest_from(int src, int nv);
    int u, best, v, nd;
    for (int i = 0; i < nv; i++) begin
      vdist[i] = FAR;
      settled[i] = 0;
    end
    vdist[src] = 0;
    while (1) begin
      u = nv;
      best = FAR;
      for (int i = 0; i < nv; i++)
        if (!settled[i] && vdist[i] < best) begin
          best = vdist[i];
          u = i;
        end
      if (u >= nv) break;
      settled[u] = 1;
      for (int e = 0; e < e_src.size(); e++) begin
        v = e_dst[e];
        if (e_src[e] != u || v >= nv || settled[v]) continue;
        nd = vdist[u] + e_cost[e];
        if (nd < vdist[v]) begin
          vdist[v] = nd;
          vpred[v] = u;
        end
      end
    end
  endtask

  task automatic add_to_tree(int v);
    if (!in_tree[v] && tree_order.size() < 256) begin
      in_tree[v] = 1;
      tree_order.push_back(v);
    end
  endtask

  task automatic push_join(int g, int cost, bit unr, bit last);
    join_t j;
    j.grp = g[4:0];
    j.cost = cost[15:0];
    j.unr = unr;
    j.last = last;
    joins_due.push_back(j);
  endtask

  task automatic build_tree();
    int nv, ng, n, g, src, td, tv, t, x, steps;
    int b_cost, b_group, b_src, b_tgt;
    bit have, found;
    nv = vc_reg < 1 ? 1 : (vc_reg > 256 ? 256 : vc_reg);
    ng = gc_reg < 1 ? 1 : (gc_reg > 32 ? 32 : gc_reg);
    for (int i = 0; i < 256; i++) in_tree[i] = 0;
    for (int i = 0; i < 32; i++) joined[i] = 0;
    tree_order.delete();
    joined[0] = 1;
    for (int m = 0; m < m_grp.size(); m++)
      if (m_grp[m] == 0 && m_vtx[m] < nv) begin
        add_to_tree(m_vtx[m]);
        break;
      end
    push_join(0, 0, 0, ng == 1);
    n = 1;
    while (n < ng) begin
      have = 0;
      b_cost = 0; b_group = 0; b_src = 0; b_tgt = 0;
      for (g = 0; g < ng; g++) begin
        if (joined[g]) continue;
        for (int m = 0; m < m_grp.size(); m++) begin
          src = m_vtx[m];
          if (m_grp[m] != g || src >= nv) continue;
          shortest_from(src, nv);
          found = 0; td = 0; tv = 0;
          for (int k = 0; k < tree_order.size(); k++) begin
            t = tree_order[k];
            if (t < nv && vdist[t] < FAR && (!found || vdist[t] < td)) begin
              found = 1;
              td = vdist[t];
              tv = t;
            end
          end
          if (found && (!have || td < b_cost)) begin
            have = 1;
            b_cost = td; b_group = g; b_src = src; b_tgt = tv;
            bpred = vpred;
          end
        end
      end
      if (!have) begin
        g = 0;
        while (g < ng && joined[g]) g++;
        push_join(g, FAR, 1, 1);
        return;
      end
      x = b_tgt;
      steps = 0;
      while (1) begin
        add_to_tree(x);
        if (x == b_src || steps >= nv) break;
        x = bpred[x];
        if (x >= nv) break;
        steps++;
      end
      joined[b_group] = 1;
      push_join(b_group, b_cost, 0, n + 1 == ng);
      n++;
    end
  endtask

  task automatic apply_item(pend_t p);
    case (p.kind)
      KIND_EDGE: begin
        if (e_src.size() < 1024) begin
          e_src.push_back(p.efrom);
          e_dst.push_back(p.eto);
          e_cost.push_back(p.ew);
        end
      end
      KIND_MEMBER: begin
        if (m_grp.size() < 256) begin
          m_grp.push_back(p.mg);
          m_vtx.push_back(p.mv);
        end
      end
      KIND_START: build_tree();
      default: ;
    endcase
  endtask

  // driver
  pend_t cur;
  pend_t wr;
  logic nx_valid, nx_we;
  int gap_left = 0;
  int burst_left = 4;
  int quiet = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      cfg_we <= 1'b0;
    end else begin
      nx_valid = in_tvalid;
      nx_we = 1'b0;
      if (in_tvalid && in_tready) begin
        apply_item(cur);
        nx_valid = 1'b0;
      end
      if (!nx_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending.size() > 0) begin
          if (!pending[0].is_cfg) begin
            cur = pending.pop_front();
            nx_valid = 1'b1;
            if (burst_left > 1) begin
              burst_left--;
            end else begin
              burst_left = $urandom_range(1, 12);
              gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
          end else if (joins_due.size() == 0) begin
            if (quiet >= QUIET) begin
              wr = pending.pop_front();
              nx_we = 1'b1;
              if (wr.cidx == CFG_VERTEX_COUNT) vc_reg = wr.cval & 9'h1ff;
              else gc_reg = wr.cval & 6'h3f;
              quiet = 0;
            end else begin
              quiet++;
            end
          end else begin
            quiet = 0;
          end
        end
      end
      in_tvalid <= nx_valid;
      in_tdata <= {7'b0, cur.mv, cur.mg, cur.ew, cur.eto, cur.efrom};
      in_tuser <= cur.kind;
      cfg_we <= nx_we;
      cfg_addr <= wr.cidx;
      cfg_wdata <= wr.cval;
    end
  end

  // monitor and receiver stalls
  join_t exp_j;
  logic rdy;
  int hold_left = 0;
  int mode = 0;
  int mode_left = 100;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        seen++;
        if (seen == 3 || seen == 120) hold_left = 600;
        if (joins_due.size() == 0) begin
          $display("%0t: unexpected transfer grp=%0d cost=%0d unr=%0d last=%0b", $time,
                   out_tdata[4:0], out_tdata[20:5], out_tdata[21], out_tlast);
          errs++;
        end else begin
          exp_j = joins_due.pop_front();
          if (out_tdata[4:0] !== exp_j.grp || out_tdata[20:5] !== exp_j.cost ||
              out_tdata[21] !== exp_j.unr || out_tlast !== exp_j.last) begin
            $display("%0t: expected grp=%0d cost=%0d unr=%0d last=%0b, %s",
                     $time, exp_j.grp, exp_j.cost, exp_j.unr, exp_j.last,
                     $sformatf("actual grp=%0d cost=%0d unr=%0d last=%0b",
                               out_tdata[4:0], out_tdata[20:5], out_tdata[21],
                               out_tlast));
            errs++;
          end
        end
      end
      if (mode_left > 0) begin
        mode_left--;
      end else begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 300);
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        case (mode)
          0: rdy = 1'b1;
          1: rdy = ($urandom_range(0, 3) != 0);
          default: rdy = ($urandom_range(0, 2) == 0);
        endcase
      end
      out_tready <= rdy;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic push_cfg(logic [CFG_ADDR_W-1:0] idx, int val);
    pend_t p;
    p = '{default: '0};
    p.is_cfg = 1;
    p.cidx = idx;
    p.cval = val[CFG_DATA_W-1:0];
    pending.push_back(p);
  endtask

  task automatic push_edge(int f, int t, int w);
    pend_t p;
    p = '{default: '0};
    p.kind = KIND_EDGE;
    p.efrom = f[7:0];
    p.eto = t[7:0];
    p.ew = w[11:0];
    pending.push_back(p);
  endtask

  task automatic push_member(int g, int v);
    pend_t p;
    p = '{default: '0};
    p.kind = KIND_MEMBER;
    p.mg = g[4:0];
    p.mv = v[7:0];
    pending.push_back(p);
  endtask

  task automatic push_kind(logic [IN_USER_W-1:0] k);
    pend_t p;
    p = '{default: '0};
    p.kind = k;
    p.efrom = $urandom_range(0, 255);
    p.eto = $urandom_range(0, 255);
    p.ew = $urandom_range(0, 4095);
    p.mg = $urandom_range(0, 31);
    p.mv = $urandom_range(0, 255);
    pending.push_back(p);
  endtask

  function automatic int pick_vertex(int nv);
    if (nv < 1) nv = 1;
    if (nv > 256) nv = 256;
    return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, nv - 1);
  endfunction

  initial begin : stim
    int made, nv, ng, cnt, r, w;
    // seedless start, then tie and range corners
    push_cfg(CFG_VERTEX_COUNT, 8);
    push_cfg(CFG_GROUP_COUNT, 3);
    push_edge(0, 1, 5);
    push_edge(1, 2, 4095);
    push_edge(2, 0, 0);
    push_edge(3, 2, 2);
    push_edge(4, 2, 2);
    push_edge(255, 0, 0);
    push_edge(0, 255, 4095);
    push_member(1, 1);
    push_member(2, 3);
    push_member(2, 4);
    push_member(1, 255);
    push_member(31, 2);
    push_kind(KIND_NONE);
    push_kind(KIND_START);
    push_member(0, 2);
    push_kind(KIND_START);
    push_cfg(CFG_VERTEX_COUNT, 0);
    push_cfg(CFG_GROUP_COUNT, 0);
    push_kind(KIND_START);
    push_cfg(CFG_VERTEX_COUNT, 511);
    push_cfg(CFG_GROUP_COUNT, 63);
    push_kind(KIND_START);
    push_cfg(CFG_VERTEX_COUNT, 256);
    push_cfg(CFG_GROUP_COUNT, 32);
    push_edge(255, 2, 1);
    push_kind(KIND_START);

    made = 0;
    while (made < RAND_ITEMS) begin
      r = $urandom_range(0, 19);
      nv = (r == 0) ? 0 : (r == 1) ? 300 : (r == 2) ? 1 : $urandom_range(3, 12);
      r = $urandom_range(0, 19);
      ng = (r == 0) ? 0 : (r == 1) ? 32 : (r == 2) ? 1 : $urandom_range(2, 5);
      push_cfg(CFG_VERTEX_COUNT, nv);
      push_cfg(CFG_GROUP_COUNT, ng);
      cnt = $urandom_range(6, 14);
      for (int i = 0; i < cnt; i++) begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          w = $urandom_range(0, 9);
          push_edge(pick_vertex(nv), pick_vertex(nv),
                    (w < 5) ? $urandom_range(0, 3) : (w == 5) ? 4095 : $urandom_range(0, 4095));
          made++;
        end else if (r < 85) begin
          push_member(($urandom_range(0, 2) != 0) ? $urandom_range(0, (ng < 2 ? 2 : ng) - 1)
                                                  : $urandom_range(0, 31),
                      pick_vertex(nv));
          made++;
        end else if (r < 90) begin
          push_kind(KIND_NONE);
        end else begin
          push_kind(KIND_START);
          made++;
        end
      end
      push_kind(KIND_START);
      made++;
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk);
    while (pending.size() != 0 || in_tvalid || joins_due.size() != 0);
    repeat (400) @(posedge clk);
    if (joins_due.size() != 0) begin
      $display("%0t: %0d expected transfers never arrived", $time, joins_due.size());
      errs++;
    end
    if (errs == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ group_steiner_tree_greedy.f @@
hw/rtl/gst_pkg.sv
hw/rtl/gst_ram.sv
hw/rtl/gst_search.sv
hw/rtl/group_steiner_tree_greedy.sv
hw/rtl/gst_chk.sv
sim/testbench.sv
